/* rtl/ntbp_pkg.sv */
// Shared types and constants for the two-bit nucleotide packer.
package ntbp_pkg;

   // Input command codes carried on req_tuser
   typedef enum logic [1:0] {
      CMD_CHAR   = 2'd0,
      CMD_HEADER = 2'd1,
      CMD_END    = 2'd2
   } cmd_type;

   // Result kinds
   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_RECORD = 1'b1;

   localparam int CHAR_W      = 8;
   localparam int CMD_W       = 2;
   localparam int COUNT_W     = 32;
   localparam int WORD_W      = 32;
   localparam int ADDR_W      = 28;
   localparam int SEQ_W       = 6;
   localparam int SLOT_W      = 4;
   localparam int RSP_DATA_W  = 136;
   localparam int RSP_USER_W  = 2;
   localparam int RSP_PAD_W   = RSP_DATA_W - (ADDR_W + WORD_W + SEQ_W + 2 * COUNT_W);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
   localparam logic [SLOT_W-1:0]  SLOT_LAST = {SLOT_W{1'b1}};

   // One result transaction as held in the output queue
   typedef struct packed {
      logic                kind;
      logic                prev_valid;
      logic                last;
      logic [ADDR_W-1:0]   word_address;
      logic [WORD_W-1:0]   packed_word;
      logic [SEQ_W-1:0]    seq_number;
      logic [COUNT_W-1:0]  seq_start;
      logic [COUNT_W-1:0]  prev_length;
   } rsp_item_type;

endpackage

/* rtl/nucleotide_two_bit_packer.sv */
// Top level of the two-bit nucleotide packer: coding, packing and result queue.
//
// The block takes one transaction per cycle on the req_ side: a nucleotide
// character (coded into two bits from ASCII bits [2:1], so lower and upper
// case agree and N codes as G), a header that opens a new sequence, or an end
// marker. Sixteen codes fill one 32-bit word, earliest in the low bits; each
// full word leaves as a word write at a shuffled word address. Headers and the
// end marker leave as boundary records; the end marker first writes out any
// partial word and then returns the block to its reset state. Each accepted
// transaction updates the packing state in the same cycle and pushes its zero,
// one or two results into a four-entry result queue, so a new transaction is
// taken every cycle as long as the queue has room for two results; the queue
// drains one result per cycle while rsp_tready is high, and throughput is
// bounded only by that port (an end marker with a partial word puts two results
// on the output side). Results are registered in the queue before they leave.
module nucleotide_two_bit_packer #(
   parameter int THREAD_BITS     = 7,
   parameter int PER_THREAD_BITS = 8,
   parameter int MAX_SEQUENCES   = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // char_code [7:0]
   input  logic [ntbp_pkg::CHAR_W-1:0]        req_tdata,
   // command [1:0]
   input  logic [ntbp_pkg::CMD_W-1:0]         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // word_address [27:0], packed_word [59:28], seq_number [65:60],
   // seq_start [97:66], prev_length [129:98], zero pad [135:130]
   output logic [ntbp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // kind [0], prev_valid [1]
   output logic [ntbp_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                               rsp_tlast
);

   localparam int SPLIT         = THREAD_BITS + PER_THREAD_BITS;
   localparam int SEQ_LIMIT_INT = (MAX_SEQUENCES - 1 > 63) ? 63 : MAX_SEQUENCES - 1;
   localparam logic [ntbp_pkg::SEQ_W-1:0] SEQ_LIMIT = SEQ_LIMIT_INT[ntbp_pkg::SEQ_W-1:0];
   localparam int QUEUE_DEPTH   = 4;
   localparam int PTR_W         = 2;
   localparam int FILL_W        = 3;
   localparam logic [FILL_W-1:0] FILL_ROOM = 3'd2;
   localparam logic [FILL_W-1:0] FILL_FULL = 3'd4;

   // packing state
   logic [ntbp_pkg::COUNT_W-1:0] char_count_ff, char_count_in;
   logic [ntbp_pkg::WORD_W-1:0]  word_buffer_ff, word_buffer_in;
   logic [ntbp_pkg::SEQ_W-1:0]   current_seq_ff, current_seq_in;
   logic                         seen_header_ff, seen_header_in;
   logic [ntbp_pkg::COUNT_W-1:0] current_start_ff, current_start_in;

   // result queue
   ntbp_pkg::rsp_item_type       queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]            fill_ff, fill_in;

   logic                         req_acc;
   logic                         rsp_acc;
   logic                         push0;
   logic                         push1;
   ntbp_pkg::rsp_item_type       item0;
   ntbp_pkg::rsp_item_type       item1;
   ntbp_pkg::rsp_item_type       head;

   logic [ntbp_pkg::SLOT_W-1:0]  slot;
   logic [1:0]                   code;
   logic [ntbp_pkg::WORD_W-1:0]  merged_word;
   logic [ntbp_pkg::ADDR_W-1:0]  word_idx;
   logic [ntbp_pkg::ADDR_W-1:0]  shuffled_addr;
   logic [ntbp_pkg::COUNT_W-1:0] seq_length;
   logic [ntbp_pkg::SEQ_W-1:0]   next_seq;

   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign req_tready = (fill_ff <= FILL_ROOM);

   // Code the character: lower case differs from upper only in bit 5,
   // so bits [2:1] give the code directly.
   assign slot        = char_count_ff[ntbp_pkg::SLOT_W-1:0];
   assign code        = req_tdata[2:1];
   assign merged_word = word_buffer_ff
                        | ({{(ntbp_pkg::WORD_W-2){1'b0}}, code} << {slot, 1'b0});

   // Shuffle the word index: top bits stay, low per-thread bits move up,
   // thread bits move to the bottom.
   assign word_idx      = char_count_ff[ntbp_pkg::COUNT_W-1:ntbp_pkg::SLOT_W];
   assign shuffled_addr = {word_idx[ntbp_pkg::ADDR_W-1:SPLIT],
                           word_idx[PER_THREAD_BITS-1:0],
                           word_idx[SPLIT-1:PER_THREAD_BITS]};

   assign seq_length = char_count_ff - current_start_ff;
   assign next_seq   = (current_seq_ff < SEQ_LIMIT) ? current_seq_ff + 6'd1 : current_seq_ff;

   // Decode the command, update the packing state and build results
   always_comb begin
      char_count_in    = char_count_ff;
      word_buffer_in   = word_buffer_ff;
      current_seq_in   = current_seq_ff;
      seen_header_in   = seen_header_ff;
      current_start_in = current_start_ff;
      push0            = 1'b0;
      push1            = 1'b0;
      item0            = '0;
      item1            = '0;

      if (req_acc) begin
         case (ntbp_pkg::cmd_type'(req_tuser))
            ntbp_pkg::CMD_CHAR: begin
               // drop characters once the counter has saturated
               if (char_count_ff != ntbp_pkg::COUNT_MAX) begin
                  char_count_in = char_count_ff + 32'd1;
                  if (slot == ntbp_pkg::SLOT_LAST) begin
                     push0              = 1'b1;
                     item0.kind         = ntbp_pkg::KIND_WORD;
                     item0.word_address = shuffled_addr;
                     item0.packed_word  = merged_word;
                     item0.last         = 1'b1;
                     word_buffer_in     = '0;
                  end else begin
                     word_buffer_in = merged_word;
                  end
               end
            end
            ntbp_pkg::CMD_HEADER: begin
               push0            = 1'b1;
               item0.kind       = ntbp_pkg::KIND_RECORD;
               item0.seq_number = seen_header_ff ? next_seq : current_seq_ff;
               item0.seq_start  = char_count_ff;
               item0.prev_length = seen_header_ff ? seq_length : '0;
               item0.prev_valid = seen_header_ff;
               item0.last       = 1'b1;
               if (seen_header_ff) begin
                  current_seq_in = next_seq;
               end
               current_start_in = char_count_ff;
               seen_header_in   = 1'b1;
            end
            ntbp_pkg::CMD_END: begin
               // flush a partial word ahead of the closing record
               if (slot != '0) begin
                  push0              = 1'b1;
                  push1              = 1'b1;
                  item0.kind         = ntbp_pkg::KIND_WORD;
                  item0.word_address = shuffled_addr;
                  item0.packed_word  = word_buffer_ff;
                  item0.last         = 1'b0;
                  item1.kind         = ntbp_pkg::KIND_RECORD;
                  item1.seq_number   = current_seq_ff;
                  item1.seq_start    = char_count_ff;
                  item1.prev_length  = seen_header_ff ? seq_length : '0;
                  item1.prev_valid   = seen_header_ff;
                  item1.last         = 1'b1;
               end else begin
                  push0             = 1'b1;
                  item0.kind        = ntbp_pkg::KIND_RECORD;
                  item0.seq_number  = current_seq_ff;
                  item0.seq_start   = char_count_ff;
                  item0.prev_length = seen_header_ff ? seq_length : '0;
                  item0.prev_valid  = seen_header_ff;
                  item0.last        = 1'b1;
               end
               char_count_in    = '0;
               word_buffer_in   = '0;
               current_seq_in   = '0;
               seen_header_in   = 1'b0;
               current_start_in = '0;
            end
            default: begin
               // unused command: drop
            end
         endcase
      end
   end

   // Advance queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff + {1'b0, push0} + {1'b0, push1};
      rd_ptr_in = rd_ptr_ff + {1'b0, rsp_acc};
      fill_in   = fill_ff + {2'b00, push0} + {2'b00, push1} - {2'b00, rsp_acc};
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff    <= '0;
         word_buffer_ff   <= '0;
         current_seq_ff   <= '0;
         seen_header_ff   <= 1'b0;
         current_start_ff <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         fill_ff          <= '0;
      end else begin
         char_count_ff    <= char_count_in;
         word_buffer_ff   <= word_buffer_in;
         current_seq_ff   <= current_seq_in;
         seen_header_ff   <= seen_header_in;
         current_start_ff <= current_start_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         fill_ff          <= fill_in;
      end
   end

   // Write results into the queue
   always_ff @(posedge clock) begin
      if (push0) begin
         queue_ff[wr_ptr_ff] <= item0;
      end
      if (push1) begin
         queue_ff[wr_ptr_ff + 2'd1] <= item1;
      end
   end

   // Present the queue head
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = {{ntbp_pkg::RSP_PAD_W{1'b0}}, head.prev_length, head.seq_start,
                        head.seq_number, head.packed_word, head.word_address};
   assign rsp_tuser  = {head.prev_valid, head.kind};
   assign rsp_tlast  = head.last;

   // Queue never overflows its four entries
   assert property (@(posedge clock) disable iff (reset) fill_ff <= FILL_FULL)
      else $error("result queue overflow");

   // An end marker always returns the counter to zero
   assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tuser == ntbp_pkg::CMD_END) |=> char_count_ff == '0)
      else $error("end marker did not clear the character count");

   // A counted character advances the counter by one
   assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_tuser == ntbp_pkg::CMD_CHAR) && (char_count_ff != ntbp_pkg::COUNT_MAX)
      |=> char_count_ff == $past(char_count_ff) + 32'd1)
      else $error("character count did not advance");

   // Sequence index stays within its limit
   assert property (@(posedge clock) disable iff (reset) current_seq_ff <= SEQ_LIMIT)
      else $error("sequence index beyond limit");

endmodule
